// ----- rtl/rg32_pkg.sv -----
// rg32_pkg: shared types, constants and helpers for the RadioGatun[32] hash unit
// used by rg32_round, rg32_seq and radiogatun32_hash_unit; depends on nothing
`default_nettype none

package rg32_pkg;

    // geometry of the mill and belt
    localparam int MILL_N       = 19;
    localparam int BELT_COLS    = 13;
    localparam int BELT_ROWS    = 3;
    localparam int BELT_N       = 39;
    localparam int BLANK_ROUNDS = 17;
    localparam int BLOCK_BYTES  = 12;

    localparam logic [7:0]  PAD_BYTE   = 8'h01;
    localparam logic [31:0] IOTA_CONST = 32'h0000_0001;

    typedef logic [31:0]                    word_t;
    typedef logic [MILL_N-1:0][31:0]        mill_t;
    typedef logic [BELT_N-1:0][31:0]        belt_t;
    typedef logic [BELT_ROWS-1:0][31:0]     blk_t;

    // input word: one message byte
    typedef struct packed {
        logic [7:0] message_byte;
        logic       final_byte;
    } in_word_t;

    // output word: one digest word
    typedef struct packed {
        logic [31:0] hash_word;
        logic        last_word;
    } out_word_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLANK,
        ST_ROUND,
        ST_LOAD
    } seq_state_t;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic busy;
        logic round_en;
        logic inject;
        logic load;
        logic sel_word2;
        logic last;
        logic clear;
    } seq_ctrl_t;

    // byte order reversal for the digest text order
    function automatic word_t byte_swap(input word_t w);
        byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rg32_round.sv -----
// rg32_round: one beltmill round with block injection in front of it
// combinational; depends on rg32_pkg
`default_nettype none

module rg32_round (
    input  wire rg32_pkg::mill_t mill_in,
    input  wire rg32_pkg::belt_t belt_in,
    input  wire rg32_pkg::blk_t  blk_in,
    output rg32_pkg::mill_t      mill_out,
    output rg32_pkg::belt_t      belt_out
);

    rg32_pkg::mill_t m_inj;
    rg32_pkg::mill_t gam;
    rg32_pkg::mill_t thet;
    rg32_pkg::belt_t b_inj;
    rg32_pkg::belt_t b_ff;

    // block injection into the first belt column and mill words 16 to 18
    genvar gm;
    generate
        for (gm = 0; gm < rg32_pkg::MILL_N; gm++) begin : g_minj
            if (gm >= rg32_pkg::MILL_N - rg32_pkg::BELT_ROWS) begin : g_x
                assign m_inj[gm] = mill_in[gm]
                                 ^ blk_in[gm - (rg32_pkg::MILL_N - rg32_pkg::BELT_ROWS)];
            end
            else begin : g_p
                assign m_inj[gm] = mill_in[gm];
            end
        end
    endgenerate

    genvar gb;
    generate
        for (gb = 0; gb < rg32_pkg::BELT_N; gb++) begin : g_belt
            localparam int ROW = gb / rg32_pkg::BELT_COLS;
            localparam int COL = gb % rg32_pkg::BELT_COLS;

            // injection
            if (COL == 0) begin : g_inj
                assign b_inj[gb] = belt_in[gb] ^ blk_in[ROW];
            end
            else begin : g_noinj
                assign b_inj[gb] = belt_in[gb];
            end

            // mill to belt feedforward
            if ((COL < 12) && ((COL % 3) == ROW)) begin : g_ff
                assign b_ff[gb] = b_inj[gb] ^ m_inj[COL + 1];
            end
            else begin : g_noff
                assign b_ff[gb] = b_inj[gb];
            end

            // belt rotation, last column wraps to the first
            if (COL == 0) begin : g_wrap
                assign belt_out[gb] = b_ff[gb + rg32_pkg::BELT_COLS - 1];
            end
            else begin : g_shift
                assign belt_out[gb] = b_ff[gb - 1];
            end
        end
    endgenerate

    // gamma with pi permutation and rho rotation
    genvar gg;
    generate
        for (gg = 0; gg < rg32_pkg::MILL_N; gg++) begin : g_gamma
            localparam int P0  = (gg * 7) % rg32_pkg::MILL_N;
            localparam int P1  = (P0 + 1) % rg32_pkg::MILL_N;
            localparam int P2  = (P0 + 2) % rg32_pkg::MILL_N;
            localparam int ROT = ((gg * (gg + 1)) / 2) % 32;
            rg32_pkg::word_t x;
            assign x = m_inj[P0] ^ (m_inj[P1] | ~m_inj[P2]);
            if (ROT == 0) begin : g_r0
                assign gam[gg] = x;
            end
            else begin : g_rn
                assign gam[gg] = (x >> ROT) | (x << (32 - ROT));
            end
        end
    endgenerate

    // theta, iota and belt feed into mill words 13 to 15
    genvar gt;
    generate
        for (gt = 0; gt < rg32_pkg::MILL_N; gt++) begin : g_theta
            assign thet[gt] = gam[gt] ^ gam[(gt + 1) % rg32_pkg::MILL_N]
                            ^ gam[(gt + 4) % rg32_pkg::MILL_N];
            if (gt == 0) begin : g_iota
                assign mill_out[gt] = thet[gt] ^ rg32_pkg::IOTA_CONST;
            end
            else if (gt >= 13 && gt < 13 + rg32_pkg::BELT_ROWS) begin : g_bfeed
                assign mill_out[gt] = thet[gt]
                                    ^ b_ff[(gt - 13) * rg32_pkg::BELT_COLS
                                           + rg32_pkg::BELT_COLS - 1];
            end
            else begin : g_plain
                assign mill_out[gt] = thet[gt];
            end
        end
    endgenerate

endmodule

`default_nettype wire

// ----- rtl/rg32_seq.sv -----
// rg32_seq: sequencer for blank rounds and digest readout
// drives the shared round unit and output load; depends on rg32_pkg
`default_nettype none

module rg32_seq #(
    parameter int OUTPUT_WORDS = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 out_free,
    output rg32_pkg::seq_ctrl_t ctrl
);

    localparam int KW = (OUTPUT_WORDS > 1) ? $clog2(OUTPUT_WORDS) : 1;
    localparam int CW = $clog2(rg32_pkg::BLANK_ROUNDS);

    rg32_pkg::seq_state_t state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 k_last;

    assign k_last = (k_reg == KW'(OUTPUT_WORDS - 1));

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rg32_pkg::ST_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        ctrl           = '0;
        ctrl.sel_word2 = k_reg[0];
        ctrl.last      = k_last;
        case (state_reg)
            rg32_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rg32_pkg::ST_BLANK;
                    cnt_next   = '0;
                    k_next     = '0;
                end
            end
            rg32_pkg::ST_BLANK:
            begin
                ctrl.busy     = 1'b1;
                ctrl.round_en = 1'b1;
                ctrl.inject   = 1'b1;
                cnt_next      = cnt_reg + CW'(1);
                if (cnt_reg == CW'(rg32_pkg::BLANK_ROUNDS - 1))
                begin
                    state_next = rg32_pkg::ST_ROUND;
                end
            end
            rg32_pkg::ST_ROUND:
            begin
                ctrl.busy     = 1'b1;
                ctrl.round_en = 1'b1;
                state_next    = rg32_pkg::ST_LOAD;
            end
            rg32_pkg::ST_LOAD:
            begin
                ctrl.busy = 1'b1;
                if (out_free)
                begin
                    ctrl.load = 1'b1;
                    if (k_last)
                    begin
                        ctrl.clear = 1'b1;
                        k_next     = '0;
                        state_next = rg32_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        state_next = k_reg[0] ? rg32_pkg::ST_ROUND : rg32_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = rg32_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/radiogatun32_hash_unit.sv -----
// radiogatun32_hash_unit: RadioGatun[32] hash, byte input and 32-bit digest output
// top level; depends on rg32_pkg, rg32_round and rg32_seq
//
// usage:
//   byte channel (byte_valid, byte_stall, byte_data): one message byte per word,
//   final_byte set on the last byte of each message; messages are one byte or more
//   hash channel (hash_valid, hash_stall, hash_data): OUTPUT_WORDS digest words,
//   last_word set on the final one
// throughput: non-final bytes are taken one per cycle while the block is not busy; a byte completing a
//   12-byte block runs its round in the same cycle through the round unit
// sequence: after a final byte the single shared round unit runs 17 blank rounds,
//   then one round per pair of digest words, each round ahead of the loads of its pair
// stall: a stalled digest word holds in the output register and the readout
//   sequencer waits; byte_stall stays high until the last word is loaded
// reset: mill, belt, block buffer and byte position clear to zero, output empty;
//   mill, belt, block buffer and byte position are cleared again after each message
`default_nettype none

module radiogatun32_hash_unit #(
    parameter int OUTPUT_WORDS = 8
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  byte_valid,
    output logic                 byte_stall,
    input  wire rg32_pkg::in_word_t byte_data,
    output logic                 hash_valid,
    input  wire                  hash_stall,
    output rg32_pkg::out_word_t  hash_data
);

    rg32_pkg::mill_t     mill_reg, mill_next, mill_rnd;
    rg32_pkg::belt_t     belt_reg, belt_next, belt_rnd;
    rg32_pkg::blk_t      buf_reg, buf_next, buf_a, buf_pad, inj_blk;
    logic [3:0]          pos_reg, pos_next, pos1, ppos;
    logic                full, acc, round_go, out_free;
    logic                hash_valid_reg, hash_valid_next;
    rg32_pkg::out_word_t hash_data_reg, hash_data_next;
    rg32_pkg::seq_ctrl_t ctrl;

    assign acc        = byte_valid && !byte_stall;
    assign byte_stall = ctrl.busy;
    assign out_free   = !hash_valid_reg || !hash_stall;
    assign hash_valid = hash_valid_reg;
    assign hash_data  = hash_data_reg;

    // byte packing into the block buffer
    assign pos1 = pos_reg + 4'd1;
    assign full = (pos1 == 4'(rg32_pkg::BLOCK_BYTES));
    assign ppos = full ? 4'd0 : pos1;

    always_comb
    begin
        buf_a = buf_reg;
        buf_a[pos_reg[3:2]][{pos_reg[1:0], 3'b000} +: 8] =
            buf_reg[pos_reg[3:2]][{pos_reg[1:0], 3'b000} +: 8] | byte_data.message_byte;
        buf_pad = full ? '0 : buf_a;
        buf_pad[ppos[3:2]][{ppos[1:0], 3'b000} +: 8] =
            buf_pad[ppos[3:2]][{ppos[1:0], 3'b000} +: 8] | rg32_pkg::PAD_BYTE;
    end

    // shared round unit input selection
    assign round_go = ctrl.round_en || (acc && full);
    assign inj_blk  = ctrl.inject ? buf_reg : ((acc && full) ? buf_a : '0);

    rg32_round u_round (
        .mill_in  (mill_reg),
        .belt_in  (belt_reg),
        .blk_in   (inj_blk),
        .mill_out (mill_rnd),
        .belt_out (belt_rnd)
    );

    rg32_seq #(
        .OUTPUT_WORDS (OUTPUT_WORDS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (acc && byte_data.final_byte),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // hash state update
    always_comb
    begin
        mill_next = mill_reg;
        belt_next = belt_reg;
        buf_next  = buf_reg;
        pos_next  = pos_reg;
        if (ctrl.clear)
        begin
            mill_next = '0;
            belt_next = '0;
            buf_next  = '0;
            pos_next  = '0;
        end
        else
        begin
            if (round_go)
            begin
                mill_next = mill_rnd;
                belt_next = belt_rnd;
            end
            if (acc)
            begin
                if (byte_data.final_byte)
                begin
                    buf_next = buf_pad;
                    pos_next = '0;
                end
                else
                begin
                    buf_next = full ? '0 : buf_a;
                    pos_next = ppos;
                end
            end
            else if (ctrl.inject)
            begin
                buf_next = '0;
            end
        end
    end

    // output register
    always_comb
    begin
        hash_valid_next = hash_valid_reg;
        hash_data_next  = hash_data_reg;
        if (ctrl.load)
        begin
            hash_valid_next          = 1'b1;
            hash_data_next.hash_word = rg32_pkg::byte_swap(ctrl.sel_word2 ? mill_reg[2]
                                                                          : mill_reg[1]);
            hash_data_next.last_word = ctrl.last;
        end
        else if (!hash_stall)
        begin
            hash_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mill_reg       <= '0;
            belt_reg       <= '0;
            buf_reg        <= '0;
            pos_reg        <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            mill_reg       <= mill_next;
            belt_reg       <= belt_next;
            buf_reg        <= buf_next;
            pos_reg        <= pos_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_data_reg <= hash_data_next;
    end

`ifndef SYNTHESIS
    // byte position stays inside a block
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < 4'(rg32_pkg::BLOCK_BYTES))
        else $error("byte position out of range");

    // a final byte puts the block into its busy phase
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && byte_data.final_byte) |=> byte_stall)
        else $error("no busy phase after final byte");

    // a digest word never overwrites one still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> (!hash_valid_reg || !hash_stall))
        else $error("digest word overwritten");

    // the state is clean after the last digest word
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (mill_reg == '0 && belt_reg == '0 && pos_reg == 4'd0))
        else $error("state not cleared after message");
`endif

endmodule

`default_nettype wire
